FILE: hdl/isdas_pkg.sv
// Shared types and constants for the isd-as address text parser.
package isdas_pkg;

  localparam int QDEPTH = 2;
  localparam int QPW = 1;
  localparam int QCW = 2;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [15:0] ISD_MAX = 16'hffff;
  localparam logic [47:0] AS_MAX = 48'hffff_ffff_ffff;

  // One classified character as it travels from the front to the back.
  typedef struct packed {
    logic       is_dig;
    logic       is_hex;
    logic       is_colon;
    logic       is_dash;
    logic [3:0] val;
    logic       last;
  } cls_t;

  // Handshake between the queue and the execution side.
  typedef struct packed {
    logic valid;
    cls_t item;
  } qhead_t;

endpackage

FILE: hdl/isdas_front.sv
// Front end: classifies each character and holds it in a two-entry queue.
module isdas_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          ch,
  input  logic                last,
  input  logic                in_valid,
  output logic                in_ready,
  output isdas_pkg::qhead_t   qhead,
  input  logic                q_pop
);

  isdas_pkg::cls_t cls;
  isdas_pkg::cls_t mem [isdas_pkg::QDEPTH];
  logic [isdas_pkg::QPW-1:0] wr_ptr;
  logic [isdas_pkg::QPW-1:0] rd_ptr;
  logic [isdas_pkg::QCW-1:0] count;
  logic push;
  logic lower;
  logic upper;

  always_comb begin
    lower = (ch >= 8'h61) && (ch <= 8'h66);
    upper = (ch >= 8'h41) && (ch <= 8'h46);
    cls.is_dig = (ch >= 8'h30) && (ch <= 8'h39);
    cls.is_hex = cls.is_dig || lower || upper;
    cls.is_colon = (ch == isdas_pkg::CH_COLON);
    cls.is_dash = (ch == isdas_pkg::CH_DASH);
    // Letters a-f and A-F both have 1..6 in the low nibble.
    cls.val = cls.is_dig ? ch[3:0] : (ch[3:0] + 4'd9);
    cls.last = last;
  end

  assign in_ready = (count != isdas_pkg::QCW'(isdas_pkg::QDEPTH));
  assign push = in_valid && in_ready;
  assign qhead.valid = (count != '0);
  assign qhead.item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10: count <= count + isdas_pkg::QCW'(1);
        2'b01: count <= count - isdas_pkg::QCW'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= isdas_pkg::QCW'(isdas_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != '0)
    else $error("pop from empty queue");

  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    (count < isdas_pkg::QCW'(isdas_pkg::QDEPTH)) |-> in_ready)
    else $error("input stalled while the queue has room");

endmodule

FILE: hdl/isdas_back.sv
// Back end: runs the parse state on classified characters and holds the result.
module isdas_back (
  input  logic              clk,
  input  logic              rst,
  input  isdas_pkg::qhead_t qhead,
  output logic              q_pop,
  output logic [63:0]       ia,
  output logic [15:0]       isd,
  output logic [47:0]       as_number,
  output logic              status,
  output logic              out_valid,
  input  logic              out_ready
);

  logic        in_as_part, in_as_part_next;
  logic [15:0] isd_acc, isd_acc_next;
  logic        isd_has_digit, isd_has_digit_next;
  logic [47:0] dec_acc, dec_acc_next;
  logic        dec_form_ok, dec_form_ok_next;
  logic [15:0] hex_group_acc, hex_group_acc_next;
  logic [31:0] hex_high_groups, hex_high_groups_next;
  logic [1:0]  group_index, group_index_next;
  logic        group_has_digit, group_has_digit_next;
  logic        hex_form_ok, hex_form_ok_next;
  logic        colon_seen, colon_seen_next;
  logic        string_bad, string_bad_next;

  isdas_pkg::cls_t c;
  logic [19:0] isd_prod;
  logic [51:0] dec_prod;
  logic        ok;
  logic [47:0] as_val;
  logic        done;

  assign c = qhead.item;
  assign q_pop = qhead.valid && (!c.last || !out_valid || out_ready);
  assign done = q_pop && c.last;

  always_comb begin
    isd_prod = ({4'd0, isd_acc} << 3) + ({4'd0, isd_acc} << 1) + 20'(c.val);
    dec_prod = ({4'd0, dec_acc} << 3) + ({4'd0, dec_acc} << 1) + 52'(c.val);

    in_as_part_next = in_as_part;
    isd_acc_next = isd_acc;
    isd_has_digit_next = isd_has_digit;
    dec_acc_next = dec_acc;
    dec_form_ok_next = dec_form_ok;
    hex_group_acc_next = hex_group_acc;
    hex_high_groups_next = hex_high_groups;
    group_index_next = group_index;
    group_has_digit_next = group_has_digit;
    hex_form_ok_next = hex_form_ok;
    colon_seen_next = colon_seen;
    string_bad_next = string_bad;

    if (!string_bad) begin
      if (!in_as_part) begin
        if (c.is_dig) begin
          if (isd_prod > {4'd0, isdas_pkg::ISD_MAX}) begin
            string_bad_next = 1'b1;
          end else begin
            isd_acc_next = isd_prod[15:0];
          end
          isd_has_digit_next = 1'b1;
        end else if (c.is_dash) begin
          if (!isd_has_digit) begin
            string_bad_next = 1'b1;
          end else begin
            in_as_part_next = 1'b1;
          end
        end else begin
          string_bad_next = 1'b1;
        end
      end else begin
        if (dec_form_ok) begin
          // The overflow test is the same as comparing 10*acc + digit with the limit.
          if (c.is_dig && (dec_prod <= {4'd0, isdas_pkg::AS_MAX})) begin
            dec_acc_next = dec_prod[47:0];
          end else begin
            dec_form_ok_next = 1'b0;
          end
        end
        if (c.is_colon) begin
          colon_seen_next = 1'b1;
        end
        if (hex_form_ok) begin
          if (c.is_colon) begin
            if (!group_has_digit || (group_index >= 2'd2)) begin
              hex_form_ok_next = 1'b0;
            end else begin
              hex_high_groups_next = {hex_high_groups[15:0], hex_group_acc};
              hex_group_acc_next = '0;
              group_index_next = group_index + 2'd1;
              group_has_digit_next = 1'b0;
            end
          end else if (c.is_hex) begin
            if (hex_group_acc > 16'h0fff) begin
              hex_form_ok_next = 1'b0;
            end else begin
              hex_group_acc_next = {hex_group_acc[11:0], c.val};
            end
            group_has_digit_next = 1'b1;
          end else begin
            hex_form_ok_next = 1'b0;
          end
        end
      end
    end

    if (string_bad_next || !in_as_part_next) begin
      ok = 1'b0;
      as_val = '0;
    end else if (colon_seen_next) begin
      ok = hex_form_ok_next && (group_index_next == 2'd2) && group_has_digit_next;
      as_val = {hex_high_groups_next, hex_group_acc_next};
    end else begin
      ok = dec_form_ok_next && group_has_digit_next;
      as_val = dec_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || done) begin
      in_as_part <= 1'b0;
      isd_acc <= '0;
      isd_has_digit <= 1'b0;
      dec_acc <= '0;
      dec_form_ok <= 1'b1;
      hex_group_acc <= '0;
      hex_high_groups <= '0;
      group_index <= '0;
      group_has_digit <= 1'b0;
      hex_form_ok <= 1'b1;
      colon_seen <= 1'b0;
      string_bad <= 1'b0;
    end else if (q_pop) begin
      in_as_part <= in_as_part_next;
      isd_acc <= isd_acc_next;
      isd_has_digit <= isd_has_digit_next;
      dec_acc <= dec_acc_next;
      dec_form_ok <= dec_form_ok_next;
      hex_group_acc <= hex_group_acc_next;
      hex_high_groups <= hex_high_groups_next;
      group_index <= group_index_next;
      group_has_digit <= group_has_digit_next;
      hex_form_ok <= hex_form_ok_next;
      colon_seen <= colon_seen_next;
      string_bad <= string_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      ia <= ok ? {isd_acc_next, as_val} : '0;
      isd <= ok ? isd_acc_next : '0;
      as_number <= ok ? as_val : '0;
      status <= !ok;
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (ia == '0) && (isd == '0) && (as_number == '0))
    else $error("invalid result carries nonzero fields");

  a_pack: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ia[63:48] == isd) && (ia[47:0] == as_number))
    else $error("packed identifier does not match its parts");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    done |=> !in_as_part && !string_bad && !colon_seen && (group_index == 2'd0))
    else $error("parse state not cleared after the last item");

endmodule

FILE: hdl/isd_as_address_text_parser_top.sv
// Parser for isd-as address strings, one character per item.
//
// Input channel: ch and last with in_valid/in_ready. Each item is one
// character; last marks the final character of a string. Output channel:
// ia, isd, as_number and status with out_valid/out_ready, one item per
// string, raised after its final character. status high means the string
// was invalid and the other fields are zero.
// Throughput is one character per cycle unless a final character waits
// for a stalled receiver. A result passes through the two-entry queue
// between the classifier and the parse state registers, and then the
// single output register behind them.
// When the receiver stalls, characters of the next string keep flowing
// into the parse state; only a final character waits for the output
// register, and the queue then fills and in_ready drops.
// Reset empties the queue, drops out_valid and returns the parse state to
// the start of a string.
module isd_as_address_text_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  ch,
  input  logic        last,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [63:0] ia,
  output logic [15:0] isd,
  output logic [47:0] as_number,
  output logic        status,
  output logic        out_valid,
  input  logic        out_ready
);

  isdas_pkg::qhead_t qhead;
  logic q_pop;

  isdas_front u_front (
    .clk      (clk),
    .rst      (rst),
    .ch       (ch),
    .last     (last),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .qhead    (qhead),
    .q_pop    (q_pop)
  );

  isdas_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qhead     (qhead),
    .q_pop     (q_pop),
    .ia        (ia),
    .isd       (isd),
    .as_number (as_number),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

FILE: tb/sv/tb_isd_as_address_text_parser_top.sv
// Self-checking testbench for the isd-as address text parser, with a scoreboard class.
module tb_isd_as_address_text_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS        = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;

  typedef logic [7:0] text_q_t[$];

  typedef struct packed {
    logic [63:0] ia;
    logic [15:0] isd;
    logic [47:0] as_num;
    logic        status;
  } addr_result_t;

  class addr_scoreboard;
    bit           in_as, isd_dig, dec_ok, grp_dig, hex_ok, colon, bad;
    bit [15:0]    isd_acc, grp_acc;
    bit [47:0]    dec_acc;
    bit [31:0]    hi_groups;
    bit [1:0]     grp_idx;
    addr_result_t expected_ids[$];
    int           mismatches;

    function new();
      mismatches = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      in_as     = 0;
      isd_acc   = 0;
      isd_dig   = 0;
      dec_acc   = 0;
      dec_ok    = 1;
      grp_acc   = 0;
      hi_groups = 0;
      grp_idx   = 0;
      grp_dig   = 0;
      hex_ok    = 1;
      colon     = 0;
      bad       = 0;
    endfunction

    function int pending();
      return expected_ids.size();
    endfunction

    // Both as forms are tracked in parallel; the choice is made on the final character.
    function void parse_char(logic [7:0] c);
      int        d, h;
      bit [31:0] v;
      bit [63:0] lim;
      d = (c >= "0" && c <= "9") ? int'(c - "0") : -1;
      h = d;
      if (c >= "a" && c <= "f") h = int'(c - "a") + 10;
      else if (c >= "A" && c <= "F") h = int'(c - "A") + 10;
      if (bad) return;
      if (!in_as) begin
        if (d >= 0) begin
          v = 32'(isd_acc) * 32'd10 + 32'(d);
          if (v > 32'(isdas_pkg::ISD_MAX)) bad = 1;
          else isd_acc = v[15:0];
          isd_dig = 1;
        end else if (c == isdas_pkg::CH_DASH) begin
          if (!isd_dig) bad = 1;
          else in_as = 1;
        end else begin
          bad = 1;
        end
        return;
      end
      if (dec_ok) begin
        if (d >= 0) begin
          lim = (64'(isdas_pkg::AS_MAX) - 64'(d)) / 64'd10;
          if (64'(dec_acc) > lim) dec_ok = 0;
          else dec_acc = dec_acc * 48'd10 + 48'(d);
        end else begin
          dec_ok = 0;
        end
      end
      if (c == isdas_pkg::CH_COLON) colon = 1;
      if (hex_ok) begin
        if (c == isdas_pkg::CH_COLON) begin
          if (!grp_dig || grp_idx >= 2) begin
            hex_ok = 0;
          end else begin
            hi_groups = {hi_groups[15:0], grp_acc};
            grp_acc   = 0;
            grp_idx   = grp_idx + 2'd1;
            grp_dig   = 0;
          end
        end else if (h >= 0) begin
          if (grp_acc > 16'h0fff) hex_ok = 0;
          else grp_acc = grp_acc * 16'd16 + 16'(h);
          grp_dig = 1;
        end else begin
          hex_ok = 0;
        end
      end
    endfunction

    function void note_char(logic [7:0] c, logic l);
      addr_result_t r;
      bit           ok;
      bit [47:0]    asv;
      parse_char(c);
      if (!l) return;
      ok  = 0;
      asv = 0;
      if (bad || !in_as) begin
        ok = 0;
      end else if (colon) begin
        ok  = hex_ok && grp_idx == 2 && grp_dig;
        asv = {hi_groups, grp_acc};
      end else begin
        ok  = dec_ok && grp_dig;
        asv = dec_acc;
      end
      if (ok) r = addr_result_t'{{isd_acc, asv}, isd_acc, asv, 1'b0};
      else r = addr_result_t'{64'd0, 16'd0, 48'd0, 1'b1};
      expected_ids.push_back(r);
      clear_parse();
    endfunction

    function void check_result(addr_result_t got);
      addr_result_t want;
      if (expected_ids.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no string pending: ia=%h status=%b", $realtime, got.ia,
                   got.status);
        return;
      end
      want = expected_ids.pop_front();
      if (got.ia !== want.ia || got.isd !== want.isd || got.as_num !== want.as_num ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp ia=%h isd=%h as=%h st=%b / act ia=%h isd=%h as=%h st=%b",
                   $realtime, want.ia, want.isd, want.as_num, want.status,
                   got.ia, got.isd, got.as_num, got.status);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic [7:0]  ch;
  logic        last;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] ia;
  logic [15:0] isd;
  logic [47:0] as_number;
  logic        status;
  logic        out_valid;
  logic        out_ready;

  addr_scoreboard sb;
  bit             no_idle;
  bit             hold_req;
  int             items_sent;
  int             idle_cycles;

  isd_as_address_text_parser_top uut (
    .clk       (clk),
    .rst       (rst),
    .ch        (ch),
    .last      (last),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ia        (ia),
    .isd       (isd),
    .as_number (as_number),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic text_q_t to_text(string s);
    text_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic string isd_text();
    int          r;
    int unsigned v;
    string       s;
    r = $urandom_range(0, 99);
    if (r < 10) v = 65535;
    else if (r < 18) v = 65536 + $urandom_range(0, 200000);
    else if (r < 40) v = $urandom_range(0, 99);
    else v = $urandom_range(0, 65535);
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) s = {"0", s};
    return s;
  endfunction

  function automatic string dec_as_text();
    int        r;
    bit [63:0] v;
    string     s;
    r = $urandom_range(0, 99);
    if (r < 15) v = $urandom_range(0, 999);
    else if (r < 25) v = 64'(isdas_pkg::AS_MAX) - $urandom_range(0, 9);
    else if (r < 35) v = 64'(isdas_pkg::AS_MAX) + 1 + $urandom_range(0, 1000);
    else if (r < 45) v = {$urandom, $urandom};
    else v = {$urandom, $urandom} >> $urandom_range(16, 60);
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 19) == 0) s = {s, "9"};
    return s;
  endfunction

  function automatic string hex_group();
    int        r;
    bit [16:0] v;
    string     s;
    r = $urandom_range(0, 99);
    if (r < 8) v = 17'h10000 + $urandom_range(0, 255);
    else if (r < 14) v = 17'h0ffff;
    else if (r < 20) v = 17'h0;
    else v = $urandom_range(0, 16'hffff);
    if (v > 17'h0ffff) s = $sformatf("%0h", v);
    else begin
      case ($urandom_range(0, 2))
        0: s = $sformatf("%0h", v[15:0]);
        1: s = $sformatf("%04h", v[15:0]);
        default: s = $sformatf("0%04h", v[15:0]);
      endcase
    end
    for (int i = 0; i < s.len(); i++)
      if (s[i] >= "a" && s[i] <= "f" && $urandom_range(0, 1)) s.putc(i, s[i] - 8'd32);
    return s;
  endfunction

  function automatic string hex_as_text();
    return {hex_group(), ":", hex_group(), ":", hex_group()};
  endfunction

  // Mostly well-formed strings with random content, then damaged strings and raw noise.
  function automatic text_q_t random_text();
    text_q_t q;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 45) return to_text({isd_text(), "-", dec_as_text()});
    if (r < 80) return to_text({isd_text(), "-", hex_as_text()});
    if (r < 92) begin
      if ($urandom_range(0, 1)) q = to_text({isd_text(), "-", dec_as_text()});
      else q = to_text({isd_text(), "-", hex_as_text()});
      case ($urandom_range(0, 3))
        0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
        1: q.delete($urandom_range(0, q.size() - 1));
        2: q.insert($urandom_range(0, q.size() - 1), 8'($urandom_range(0, 255)));
        default: q.push_back(8'($urandom_range(0, 255)));
      endcase
      return q;
    end
    repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  task automatic send_char(logic [7:0] c, logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ch       <= c;
    last     <= l;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_char(c, l);
    items_sent++;
  endtask

  task automatic send_text(text_q_t t);
    foreach (t[i]) send_char(t[i], i == t.size() - 1);
  endtask

  task automatic pause_input();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: random ready pattern, with one long hold-off when requested.
  initial begin
    int gap;
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(addr_result_t'{ia, isd, as_number, status});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    string   directed[$];
    text_q_t t;
    sb          = new();
    no_idle     = 0;
    hold_req    = 0;
    items_sent  = 0;
    idle_cycles = 0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    ch       <= 8'h00;
    last     <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    directed = '{"0-0", "65535-281474976710655", "65536-1", "-5", "12-", "12", "1-2-3",
                 "1- 7", "1-+7", "1-0x1f", " 1-1", "1-281474976710656",
                 "1-18446744073709551616", "1-ffff:ffff:ffff", "9-FFFF:0:aBcD", "1-1:2",
                 "1-1:2:3:4", "1-1:2:3x", "1-1::3", "1-1:2:10000", "7-00000f:0:0",
                 "1-12a", "99999999999-1", "1-:1:2", "1-1:2:"};
    foreach (directed[i]) send_text(to_text(directed[i]));
    // A NUL byte inside the as part and as the very first character.
    t = to_text("1-1");
    t.push_back(8'h00);
    send_text(t);
    t = '{8'h00, "-", "1"};
    send_text(t);
    pause_input();

    while (items_sent < ITEMS / 2) send_text(random_text());

    // The receiver stalls while strings keep coming, so the input side backs up.
    hold_req = 1;
    repeat (12) send_text(random_text());
    pause_input();

    no_idle = 1;
    repeat (15) send_text(random_text());
    no_idle = 0;

    while (items_sent < ITEMS) send_text(random_text());
    pause_input();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/isdas_pkg.sv
hdl/isdas_front.sv
hdl/isdas_back.sv
hdl/isd_as_address_text_parser_top.sv
tb/sv/tb_isd_as_address_text_parser_top.sv
